// File: hw/rtl/scts_pkg.sv
// Package with shared types and constants of the sparse column transpose sort block.
`timescale 1ns / 1ps

package scts_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 32;
    localparam int INDEX_W = 32;
    localparam int VALUE_W = 64;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = $clog2(INDEX_W);

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic add;
        logic insert;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic is_last;
        logic emit_final;
    } status_t;

endpackage

// File: hw/rtl/sparse_column_transpose_sort_top.sv
// Top level of the sparse column transpose sort block.
`timescale 1ns / 1ps

// Usage: a request is taken when start is high and busy is low, carrying
// old_index, entry_value and last_in. Each entry is remapped by a restoring
// divider (one quotient bit a cycle), a 16 by 16 multiply and an add, then
// placed in a sorted chain of insertion cells. No new entry is taken before
// the current one has been inserted, as busy is high. When the entry marked
// last has been inserted, the column is emitted in ascending new_index order,
// one result per cycle, each marked by result_valid for one cycle; busy stays
// high until the final result (last_out) has been shown. Entries beyond
// MAX_ENTRIES are dropped and overflow is raised on all results of that column.
// Users must write registers via cfg_valid, cfg_index and cfg_data only while
// the block is idle, which it does not enforce; cfg_ready is always high. Reset
// clears the buffer fill count and overflow flag and sets both row and column
// counts to 1. The receiver cannot stall, so results are never held back.
module sparse_column_transpose_sort_top #(
    parameter int MAX_ENTRIES = scts_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [scts_pkg::INDEX_W-1:0]        old_index,
    input  logic [scts_pkg::VALUE_W-1:0]        entry_value,
    input  logic                                last_in,
    output logic                                result_valid,
    output logic [scts_pkg::INDEX_W-1:0]        new_index,
    output logic [scts_pkg::VALUE_W-1:0]        value_out,
    output logic                                last_out,
    output logic                                overflow,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scts_pkg::CFG_W-1:0]          cfg_data
);

    scts_pkg::cmd_t    cmd;
    scts_pkg::status_t status;

    assign cfg_ready = 1'b1;
    assign result_valid = cmd.emit;

    scts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    scts_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .old_index   (old_index),
        .entry_value (entry_value),
        .last_in     (last_in),
        .new_index   (new_index),
        .value_out   (value_out),
        .last_out    (last_out),
        .overflow    (overflow)
    );

endmodule

// File: hw/rtl/scts_ctrl.sv
// Controller state machine of the sparse column transpose sort block.
`timescale 1ns / 1ps

module scts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  scts_pkg::status_t status,
    output scts_pkg::cmd_t    cmd,
    output logic              busy
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV    = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_ADD    = 6'b001000,
        ST_INSERT = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add = 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = status.is_last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_final)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// File: hw/rtl/scts_datapath.sv
// Datapath with divider, remap multiplier and sorted insertion cell chain.
`timescale 1ns / 1ps

module scts_datapath #(
    parameter int MAX_ENTRIES = scts_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scts_pkg::cmd_t                      cmd,
    output scts_pkg::status_t                   status,
    input  logic                                cfg_valid,
    input  logic [scts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scts_pkg::CFG_W-1:0]          cfg_data,
    input  logic [scts_pkg::INDEX_W-1:0]        old_index,
    input  logic [scts_pkg::VALUE_W-1:0]        entry_value,
    input  logic                                last_in,
    output logic [scts_pkg::INDEX_W-1:0]        new_index,
    output logic [scts_pkg::VALUE_W-1:0]        value_out,
    output logic                                last_out,
    output logic                                overflow
);

    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int IW = scts_pkg::INDEX_W;
    localparam int VW = scts_pkg::VALUE_W;
    localparam int CW = scts_pkg::CFG_W;
    localparam int DW = scts_pkg::DIV_CNT_W;

    logic [CW-1:0]     row_count_reg;
    logic [CW-1:0]     col_count_reg;
    logic [IW-1:0]     quot_reg;
    logic [CW-1:0]     rem_reg;
    logic [DW-1:0]     div_cnt_reg;
    logic [IW-1:0]     prod_reg;
    logic [IW-1:0]     key_reg;
    logic [VW-1:0]     val_reg;
    logic              last_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              overflow_reg;
    logic [IW-1:0]     held_index_reg [MAX_ENTRIES];
    logic [VW-1:0]     held_value_reg [MAX_ENTRIES];

    logic [CW-1:0]     divisor;
    logic [CW:0]       trial;
    logic              fits;
    logic              full;
    logic [MAX_ENTRIES-1:0] gt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CW'(1);
            col_count_reg <= CW'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                scts_pkg::REG_ROW_COUNT: row_count_reg <= cfg_data;
                scts_pkg::REG_COL_COUNT: col_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign divisor = (row_count_reg == '0) ? CW'(1) : row_count_reg;
    assign trial = {rem_reg, quot_reg[IW-1]};
    assign fits = (trial >= {1'b0, divisor});
    assign full = (fill_reg == FILL_W'(MAX_ENTRIES));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quot_reg <= old_index;
            rem_reg <= '0;
            val_reg <= entry_value;
            last_reg <= last_in;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
            quot_reg <= {quot_reg[IW-2:0], fits};
        end
        if (cmd.mul)
        begin
            prod_reg <= IW'(rem_reg) * IW'(col_count_reg);
        end
        if (cmd.add)
        begin
            key_reg <= prod_reg + quot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DW'(1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            gt[i] = (FILL_W'(i) < fill_reg) && (held_index_reg[i] > key_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert && !full)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (gt[i] || (FILL_W'(i) == fill_reg))
                begin
                    if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                    begin
                        held_index_reg[i] <= held_index_reg[(i > 0) ? i - 1 : 0];
                        held_value_reg[i] <= held_value_reg[(i > 0) ? i - 1 : 0];
                    end
                    else
                    begin
                        held_index_reg[i] <= key_reg;
                        held_value_reg[i] <= val_reg;
                    end
                end
            end
        end
        else if (cmd.emit)
        begin
            for (int i = 0; i < MAX_ENTRIES - 1; i++)
            begin
                held_index_reg[i] <= held_index_reg[i + 1];
                held_value_reg[i] <= held_value_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.insert)
        begin
            if (full)
            begin
                overflow_reg <= 1'b1;
            end
            else
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
        else if (cmd.emit)
        begin
            fill_reg <= fill_reg - FILL_W'(1);
            if (fill_reg == FILL_W'(1))
            begin
                overflow_reg <= 1'b0;
            end
        end
    end

    assign status.div_done = (div_cnt_reg == DW'(IW - 1));
    assign status.is_last = last_reg;
    assign status.emit_final = (fill_reg == FILL_W'(1));

    assign new_index = held_index_reg[0];
    assign value_out = held_value_reg[0];
    assign last_out = (fill_reg == FILL_W'(1));
    assign overflow = overflow_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(MAX_ENTRIES))
        else $error("fill count above capacity");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (fill_reg != '0))
        else $error("emission from an empty buffer");

    a_overflow_set: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && full) |=> overflow_reg)
        else $error("dropped entry did not raise overflow");

endmodule

// File: dv/sparse_column_transpose_sort_checker.sv
// Checker that predicts and compares the sorted results of the transpose sort block.
`timescale 1ns / 1ps

module sparse_column_transpose_sort_checker #(
    parameter int MAX_ENTRIES = scts_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [scts_pkg::INDEX_W-1:0]   old_index,
    input  logic [scts_pkg::VALUE_W-1:0]   entry_value,
    input  logic                           last_in,
    input  logic                           result_valid,
    input  logic [scts_pkg::INDEX_W-1:0]   new_index,
    input  logic [scts_pkg::VALUE_W-1:0]   value_out,
    input  logic                           last_out,
    input  logic                           overflow,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [scts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scts_pkg::CFG_W-1:0]     cfg_data,
    output int                             errors,
    output int                             pending
);

    typedef struct packed {
        logic [scts_pkg::INDEX_W-1:0] idx;
        logic [scts_pkg::VALUE_W-1:0] val;
        logic                         last;
        logic                         ovf;
    } sorted_entry_t;

    sorted_entry_t                sorted_q[$];
    logic [scts_pkg::CFG_W-1:0]   rows;
    logic [scts_pkg::CFG_W-1:0]   cols;
    logic [scts_pkg::INDEX_W-1:0] keys [MAX_ENTRIES];
    logic [scts_pkg::VALUE_W-1:0] vals [MAX_ENTRIES];
    int                           fill;
    logic                         dropped;

    function automatic logic [scts_pkg::INDEX_W-1:0] transpose_index(
        logic [scts_pkg::INDEX_W-1:0] idx);
        logic [63:0] div;
        logic [63:0] sum;
        div = (rows == '0) ? 64'd1 : {48'd0, rows};
        sum = ({32'd0, idx} % div) * {48'd0, cols} + {32'd0, idx} / div;
        return sum[scts_pkg::INDEX_W-1:0];
    endfunction

    assign pending = sorted_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [scts_pkg::INDEX_W-1:0] key;
        int pos;
        sorted_entry_t e;
        if (!rst_n)
        begin
            rows = 16'd1;
            cols = 16'd1;
            fill = 0;
            dropped = 1'b0;
            errors = 0;
            sorted_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == scts_pkg::REG_ROW_COUNT)
                    rows = cfg_data;
                else if (cfg_index == scts_pkg::REG_COL_COUNT)
                    cols = cfg_data;
            end
            if (result_valid)
            begin
                if (sorted_q.size() == 0)
                begin
                    $error("unexpected result new_index=%h", new_index);
                    errors++;
                end
                else
                begin
                    e = sorted_q.pop_front();
                    if (new_index !== e.idx)
                    begin
                        $error("new_index expected %h actual %h", e.idx, new_index);
                        errors++;
                    end
                    if (value_out !== e.val)
                    begin
                        $error("value_out expected %h actual %h", e.val, value_out);
                        errors++;
                    end
                    if (last_out !== e.last)
                    begin
                        $error("last_out expected %b actual %b", e.last, last_out);
                        errors++;
                    end
                    if (overflow !== e.ovf)
                    begin
                        $error("overflow expected %b actual %b", e.ovf, overflow);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                key = transpose_index(old_index);
                if (fill >= MAX_ENTRIES)
                    dropped = 1'b1;
                else
                begin
                    pos = fill;
                    while (pos > 0 && keys[pos-1] > key)
                    begin
                        keys[pos] = keys[pos-1];
                        vals[pos] = vals[pos-1];
                        pos--;
                    end
                    keys[pos] = key;
                    vals[pos] = entry_value;
                    fill++;
                end
                if (last_in)
                begin
                    for (int k = 0; k < fill; k++)
                    begin
                        e.idx = keys[k];
                        e.val = vals[k];
                        e.last = (k + 1 == fill);
                        e.ovf = dropped;
                        sorted_q.push_back(e);
                    end
                    fill = 0;
                    dropped = 1'b0;
                end
            end
        end
    end

endmodule

// File: dv/sparse_column_transpose_sort_top_test.sv
// Testbench top that drives columns and register writes into the transpose sort block.
`timescale 1ns / 1ps

module sparse_column_transpose_sort_top_test;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [scts_pkg::INDEX_W-1:0]   old_index;
    logic [scts_pkg::VALUE_W-1:0]   entry_value;
    logic                           last_in;
    logic                           result_valid;
    logic [scts_pkg::INDEX_W-1:0]   new_index;
    logic [scts_pkg::VALUE_W-1:0]   value_out;
    logic                           last_out;
    logic                           overflow;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [scts_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [scts_pkg::CFG_W-1:0]     cfg_data;
    int                             errors;
    int                             pending;
    int                             entries_sent;
    bit                             calm;
    logic [scts_pkg::CFG_W-1:0]     cur_rows;
    logic [scts_pkg::CFG_W-1:0]     cur_cols;
    logic [scts_pkg::INDEX_W-1:0]   prev_index;

    sparse_column_transpose_sort_top dut (.*);

    sparse_column_transpose_sort_checker checker_i (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_entry(logic [scts_pkg::INDEX_W-1:0] idx,
                              logic [scts_pkg::VALUE_W-1:0] val, logic last);
        if (!calm && $urandom_range(99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1'b1;
        old_index <= idx;
        entry_value <= val;
        last_in <= last;
        prev_index = idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        entries_sent++;
    endtask

    task automatic go_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [scts_pkg::CFG_IDX_W-1:0] idx,
                             logic [scts_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == scts_pkg::REG_ROW_COUNT)
            cur_rows = data;
        else
            cur_cols = data;
        @(posedge clk);
    endtask

    function automatic logic [scts_pkg::INDEX_W-1:0] pick_index();
        logic [63:0] span;
        logic [63:0] pick;
        int r;
        span = ((cur_rows == '0) ? 64'd1 : {48'd0, cur_rows}) * {48'd0, cur_cols};
        r = $urandom_range(99);
        if (r < 15)
            return prev_index;
        if (r < 40)
            return $urandom;
        pick = {32'd0, $urandom} % span;
        return pick[scts_pkg::INDEX_W-1:0];
    endfunction

    task automatic random_column(int n);
        for (int k = 0; k < n; k++)
            send_entry(pick_index(), {$urandom, $urandom}, k == n - 1);
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        start <= 1'b0;
        old_index <= '0;
        entry_value <= '0;
        last_in <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= scts_pkg::REG_ROW_COUNT;
        cfg_data <= '0;
        entries_sent = 0;
        calm = 1'b0;
        cur_rows = 16'd1;
        cur_cols = 16'd1;
        prev_index = '0;
        repeat (11) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        send_entry(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_entry(32'd0, 64'd0, 1'b0);
        send_entry(32'd7, 64'h1, 1'b0);
        send_entry(32'd7, 64'h2, 1'b1);
        send_entry(32'd5, 64'h8000_0000_0000_0000, 1'b1);
        go_idle();
        write_reg(scts_pkg::REG_ROW_COUNT, 16'd0);
        write_reg(scts_pkg::REG_COL_COUNT, 16'hFFFF);
        go_idle();
        send_entry(32'hFFFF_FFFF, 64'hA5A5_A5A5_5A5A_5A5A, 1'b0);
        send_entry(32'd3, 64'h3, 1'b1);
        go_idle();
        write_reg(scts_pkg::REG_ROW_COUNT, 16'hFFFF);
        go_idle();
        send_entry(32'hFFFF_FFFF, 64'h5, 1'b0);
        send_entry(32'hFFFE, 64'h6, 1'b0);
        send_entry(32'h0001_0000, 64'h7, 1'b1);
        go_idle();
        for (int k = 0; k < 34; k++)
            send_entry($urandom, {$urandom, $urandom}, k == 33);
        go_idle();

        while (entries_sent < 90)
        begin
            write_reg(scts_pkg::REG_ROW_COUNT,
                      ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 300)));
            write_reg(scts_pkg::REG_COL_COUNT,
                      ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 300)));
            calm = ($urandom_range(5) == 0);
            go_idle();
            for (int c = 0; c < 4; c++)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(31, 35) : $urandom_range(1, 8);
                random_column(n);
            end
            go_idle();
        end
        write_reg(scts_pkg::REG_ROW_COUNT, 16'd1);
        write_reg(scts_pkg::REG_COL_COUNT, 16'd1);
        go_idle();
        random_column(6);
        go_idle();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
